// File: sv/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg
// Shared types and codes for the key/value line tokenizer: character
// constants, command opcodes passed from front to back, and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package kvlt_pkg;

  // Characters of interest
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Default depth of the held-blank buffer
  localparam int PENDING_MAX_DEF = 32;

  // Command queue depth and pointer width
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Result kinds
  localparam logic [2:0] KIND_KEY_CHAR  = 3'd0;
  localparam logic [2:0] KIND_VAL_CHAR  = 3'd1;
  localparam logic [2:0] KIND_COMMIT    = 3'd2;
  localparam logic [2:0] KIND_NO_EQUALS = 3'd3;
  localparam logic [2:0] KIND_UNTERM    = 3'd4;
  localparam logic [2:0] KIND_END       = 3'd5;

  // Command opcodes
  localparam logic [2:0] OP_BLANK = 3'd0;  // hold a blank (ch is space or tab)
  localparam logic [2:0] OP_CLEAR = 3'd1;  // drop held blanks
  localparam logic [2:0] OP_CHAR  = 3'd2;  // flush held blanks as kind, then emit ch
  localparam logic [2:0] OP_MARK  = 3'd3;  // emit marker of kind with overflow flag
  localparam logic [2:0] OP_END   = 3'd4;  // emit end of text

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] kind;
    logic [7:0] ch;
    logic       tail_end;  // marker is followed by an end result
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/kvlt_front.sv
// ----------------------------------------------------------------------------
// kvlt_front
// Accepts text bytes, tracks the line phase and CR/LF pairing, and turns
// each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kvlt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] text_byte
  input  wire logic              s_tuser,   // [0] end_of_text
  output logic                   push,
  input  wire logic              push_ready,
  output kvlt_pkg::cmd_t         push_cmd
);
  import kvlt_pkg::*;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VLEAD = 2'd2;
  localparam logic [1:0] PH_VAL   = 2'd3;

  logic [1:0] phase, phase_next;
  logic       acr, acr_next;
  logic       accept;
  logic       need;
  logic       is_blank, is_eol;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && need;
  assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
  assign is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);

  // Classify the byte and pick the command
  always_comb begin
    phase_next = phase;
    acr_next   = acr;
    need       = 1'b0;
    push_cmd   = '{op: OP_CHAR, kind: KIND_KEY_CHAR, ch: s_tdata, tail_end: 1'b0};
    if (s_tuser) begin
      need       = 1'b1;
      phase_next = PH_LEAD;
      acr_next   = 1'b0;
      if (phase != PH_LEAD) begin
        push_cmd.op       = OP_MARK;
        push_cmd.kind     = KIND_UNTERM;
        push_cmd.tail_end = 1'b1;
      end else begin
        push_cmd.op = OP_END;
      end
    end else if ((s_tdata == CH_LF) && acr) begin
      acr_next = 1'b0;
    end else begin
      acr_next = (s_tdata == CH_CR);
      if (is_eol) begin
        phase_next    = PH_LEAD;
        push_cmd.op   = OP_MARK;
        push_cmd.kind = (phase == PH_KEY) ? KIND_NO_EQUALS : KIND_COMMIT;
        need          = (phase != PH_LEAD);
      end else if (is_blank) begin
        push_cmd.op = OP_BLANK;
        need        = (phase == PH_KEY) || (phase == PH_VAL);
      end else begin
        unique case (phase)
          PH_LEAD: begin
            if (s_tdata == CH_EQUALS) begin
              phase_next = PH_VLEAD;
            end else begin
              need       = 1'b1;
              phase_next = PH_KEY;
            end
          end
          PH_KEY: begin
            need = 1'b1;
            if (s_tdata == CH_EQUALS) begin
              push_cmd.op = OP_CLEAR;
              phase_next  = PH_VLEAD;
            end
          end
          PH_VLEAD: begin
            need          = 1'b1;
            push_cmd.kind = KIND_VAL_CHAR;
            phase_next    = PH_VAL;
          end
          default: begin
            need          = 1'b1;
            push_cmd.kind = KIND_VAL_CHAR;
          end
        endcase
      end
    end
  end

  // Advance line state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      acr   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      acr   <= acr_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/kvlt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// kvlt_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module kvlt_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire kvlt_pkg::cmd_t  wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output kvlt_pkg::cmd_t       rd_data
);
  import kvlt_pkg::*;

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_wr, do_rd;

  assign wr_ready = (fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Store commands
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/kvlt_back.sv
// ----------------------------------------------------------------------------
// kvlt_back
// Executes commands: holds pending blanks in a small memory, flushes them
// ahead of key/value characters, and drives the registered result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kvlt_back #(
  parameter int PENDING_MAX = kvlt_pkg::PENDING_MAX_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire kvlt_pkg::cmd_t  cmd,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,   // [7:0] char_out
  output logic [3:0]           m_tuser,   // [2:0] kind, [3] blank_overflow
  output logic                 m_tlast    // last_of_run
);
  import kvlt_pkg::*;

  localparam int AW = (PENDING_MAX > 1) ? $clog2(PENDING_MAX) : 1;
  localparam int CW = $clog2(PENDING_MAX + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] rd_addr;
  logic          rd_tab;
  logic          wr_en;
  logic          mem [PENDING_MAX];

  logic          slot_free;
  logic          ld;
  logic [2:0]    ld_kind;
  logic [7:0]    ld_ch;
  logic          ld_ovf;
  logic          ld_last;

  assign slot_free = !m_tvalid || m_tready;

  // Sequence the command at the queue head
  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    idx_next   = idx;
    rd_addr    = '0;
    wr_en      = 1'b0;
    cmd_ready  = 1'b0;
    ld         = 1'b0;
    ld_kind    = cmd.kind;
    ld_ch      = 8'h00;
    ld_ovf     = 1'b0;
    ld_last    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_BLANK: begin
              cmd_ready = 1'b1;
              if (count < CW'(PENDING_MAX)) begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd_ready  = 1'b1;
              count_next = '0;
            end
            OP_CHAR: begin
              if (count != '0) begin
                state_next = ST_FLUSH;
                idx_next   = '0;
              end else if (slot_free) begin
                ld        = 1'b1;
                ld_ch     = cmd.ch;
                cmd_ready = 1'b1;
              end
            end
            OP_MARK: begin
              if (slot_free) begin
                ld         = 1'b1;
                ld_ovf     = ovf;
                ld_last    = !cmd.tail_end;
                count_next = '0;
                ovf_next   = 1'b0;
                if (cmd.tail_end) begin
                  state_next = ST_TAIL;
                end else begin
                  cmd_ready = 1'b1;
                end
              end
            end
            OP_END: begin
              if (slot_free) begin
                ld         = 1'b1;
                ld_kind    = KIND_END;
                cmd_ready  = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
              end
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        rd_addr = idx;
        if (slot_free) begin
          ld      = 1'b1;
          ld_ch   = rd_tab ? CH_TAB : CH_SPACE;
          ld_last = 1'b0;
          if (CW'(idx) + CW'(1) == count) begin
            state_next = ST_IDLE;
            count_next = '0;
          end else begin
            idx_next = idx + 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          ld         = 1'b1;
          ld_kind    = KIND_END;
          cmd_ready  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Blank memory: write held blank, registered read for flush
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= (cmd.ch == CH_TAB);
    end
    rd_tab <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      idx   <= idx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      m_tdata <= ld_ch;
      m_tuser <= {ld_ovf, ld_kind};
      m_tlast <= ld_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/key_value_line_tokenizer_unit.sv
// Path: a taken byte's command is registered in the command queue, then its result in the output
// register; held blanks are flushed ahead of it after a state that starts the flush.
// Throughput: one byte per cycle while the back end keeps up; a flush of held blanks
// occupies the back end and the 4-entry command queue absorbs bursts.
// Reset (rst, synchronous): clears line phase, queue, blank count and output valid;
// the blank memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_unit
// Splits a byte stream into key=value lines, streaming key and value characters
// then a commit, reject or unterminated marker per non-blank line, and an end result.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_line_tokenizer_unit #(
  parameter int PENDING_MAX = kvlt_pkg::PENDING_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  input  wire logic       s_tuser,   // [0] end_of_text
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] char_out
  output logic [3:0]      m_tuser,   // [2:0] kind, [3] blank_overflow
  output logic            m_tlast    // last_of_run
);
  import kvlt_pkg::*;

  logic push, push_ready;
  cmd_t push_cmd;
  logic head_valid, head_ready;
  cmd_t head_cmd;

  // Front: classify bytes
  kvlt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Queue between front and back
  kvlt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  (push_cmd),
    .rd_valid (head_valid),
    .rd_ready (head_ready),
    .rd_data  (head_cmd)
  );

  // Back: execute commands and emit results
  kvlt_back #(
    .PENDING_MAX (PENDING_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd_ready (head_ready),
    .cmd       (head_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
